>>> sv/psrb_pkg.sv
// Shared types and constants for the planar sprite row blitter.
// No dependencies; imported by every module of the block.
package psrb_pkg;

    localparam int ADDR_W     = 20;
    localparam int LONG_W     = 32;
    localparam int WORD_W     = 16;
    localparam int SHIFT_W    = 4;
    localparam int POS_X_W    = 10;
    localparam int POS_Y_W    = 8;
    localparam int ROW_W      = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int XCMP_W     = 14;
    localparam int CNT_W      = 3;
    localparam int SLOTS      = 4;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    localparam int DEF_LONGS_PER_LINE = 40;
    localparam int DEF_RIGHT_LIMIT    = 304;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_BASE   = 2'd0;
    localparam t_cfg_idx CFG_POS_X        = 2'd1;
    localparam t_cfg_idx CFG_POS_Y        = 2'd2;
    localparam t_cfg_idx CFG_COMBINE_MODE = 2'd3;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_OR        = 2'd0;
    localparam t_op OP_XOR       = 2'd1;
    localparam t_op OP_OVERWRITE = 2'd2;
    localparam t_op OP_RESERVED  = 2'd3;

    typedef struct packed {
        logic valid;
        logic left_en;
        logic right_en;
    } t_row_ctrl;

endpackage

>>> sv/psrb_lane.sv
// One long lane: splits a plane-pair long into its left and right group parts.
// Depends on psrb_pkg.
module psrb_lane (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic [psrb_pkg::LONG_W-1:0]        i_long,
    input  logic [psrb_pkg::SHIFT_W-1:0]       i_shift,
    output logic [psrb_pkg::LONG_W-1:0]        o_left,
    output logic [psrb_pkg::LONG_W-1:0]        o_right
);
    import psrb_pkg::*;

    logic [WORD_W-1:0]      half_mask;
    logic [LONG_W-1:0]      mask;
    logic [SHIFT_W:0]       back_shift;
    logic [LONG_W-1:0]      n_left;
    logic [LONG_W-1:0]      n_right;
    logic [LONG_W-1:0]      r_left;
    logic [LONG_W-1:0]      r_right;

    always_comb begin
        half_mask  = WORD_W'(((WORD_W+1)'(1) << i_shift) - (WORD_W+1)'(1));
        mask       = {half_mask, half_mask};
        back_shift = (SHIFT_W+1)'(WORD_W) - (SHIFT_W+1)'(i_shift);
        n_left     = (i_long & ~mask) >> i_shift;
        n_right    = (i_long & mask) << back_shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

>>> sv/psrb_merge.sv
// Merge stage: gathers the lane results of one row into write commands
// and issues them one per cycle while i_ready is high. Depends on psrb_pkg.
module psrb_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psrb_pkg::t_row_ctrl           i_row,
    input  logic [psrb_pkg::LONG_W-1:0]   i_left_lo,
    input  logic [psrb_pkg::LONG_W-1:0]   i_left_hi,
    input  logic [psrb_pkg::LONG_W-1:0]   i_right_lo,
    input  logic [psrb_pkg::LONG_W-1:0]   i_right_hi,
    input  logic [psrb_pkg::ADDR_W-1:0]   i_line_off,
    input  logic [psrb_pkg::ADDR_W-1:0]   i_base_off,
    output logic                          o_take_row,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [psrb_pkg::ADDR_W-1:0]   o_addr,
    output logic [psrb_pkg::LONG_W-1:0]   o_data,
    output logic                          o_last
);
    import psrb_pkg::*;

    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [ADDR_W-1:0]  r_addr;
    logic [LONG_W-1:0]  r_data [SLOTS];
    logic               take;
    logic               load;

    assign take = (r_cnt != '0) && i_ready;
    assign load = i_row.valid && ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && take));

    always_comb begin
        n_cnt = (i_row.left_en ? CNT_W'(2) : CNT_W'(0)) +
                (i_row.right_en ? CNT_W'(2) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_addr <= {i_line_off[ADDR_W-1:1], 1'b0} + i_base_off;
            if (i_row.left_en) begin
                r_data[0] <= i_left_lo;
                r_data[1] <= i_left_hi;
            end else begin
                r_data[0] <= i_right_lo;
                r_data[1] <= i_right_hi;
            end
            r_data[2] <= i_right_lo;
            r_data[3] <= i_right_hi;
        end else if (take) begin
            r_addr <= r_addr + ADDR_W'(1);
            for (int i = 0; i < SLOTS - 1; i++) begin
                r_data[i] <= r_data[i+1];
            end
        end
    end

    assign o_take_row = load;
    assign o_valid    = (r_cnt != '0);
    assign o_addr     = r_addr;
    assign o_data     = r_data[0];
    assign o_last     = (r_cnt == CNT_W'(1));

endmodule

>>> sv/planar_sprite_row_blitter.sv
// Planar sprite row blitter: top level with configuration, row counter and lanes.
// Depends on psrb_pkg, psrb_lane and psrb_merge.
//
// Each accepted item is one sprite row (four 16-bit planes in two longs) and
// yields two or four long write commands: the left pair unless pos_x is
// negative, the right pair unless pos_x is above RIGHT_LIMIT. Two lanes shift
// both longs at once and a merge stage issues the commands over the single
// output port, one per cycle while m_axis_tready is high; that one write
// port sets the rate. A row passes the row and lane registers, then the merge
// registers, before its first command appears; the next row is taken while
// the previous commands drain. Configuration writes belong in idle periods.
module planar_sprite_row_blitter #(
    parameter int LONGS_PER_LINE = psrb_pkg::DEF_LONGS_PER_LINE,
    parameter int RIGHT_LIMIT    = psrb_pkg::DEF_RIGHT_LIMIT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psrb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // planes_low [31:0], planes_high [63:32]
    input  logic [psrb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // write_address [19:0], write_data [51:20], write_op [53:52], zero [55:54]
    output logic [psrb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import psrb_pkg::*;

    logic [ADDR_W-1:0]          r_frame_base;
    logic signed [POS_X_W-1:0]  r_pos_x;
    logic [POS_Y_W-1:0]         r_pos_y;
    t_op                        r_combine_mode;
    logic [ROW_W-1:0]           r_row_index;
    logic [ADDR_W-1:0]          r_row_off;

    t_row_ctrl                  r_row;
    t_row_ctrl                  n_row;
    logic [ADDR_W-1:0]          r_line_off;
    logic [ADDR_W-1:0]          n_line_off;
    logic [ADDR_W-1:0]          r_base_off;
    logic [ADDR_W-1:0]          n_base_off;

    logic signed [XCMP_W-1:0]   x_ext;
    logic [ADDR_W-1:0]          x_group;
    logic [ADDR_W-1:0]          y_off;
    logic                       accept;
    logic                       take_row;
    logic [LONG_W-1:0]          left_lo;
    logic [LONG_W-1:0]          left_hi;
    logic [LONG_W-1:0]          right_lo;
    logic [LONG_W-1:0]          right_hi;
    logic [ADDR_W-1:0]          out_addr;
    logic [LONG_W-1:0]          out_data;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base   <= '0;
            r_pos_x        <= '0;
            r_pos_y        <= '0;
            r_combine_mode <= OP_OR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_BASE:   r_frame_base <= i_cfg_data[ADDR_W-1:0];
                CFG_POS_X:        r_pos_x      <= i_cfg_data[POS_X_W-1:0];
                CFG_POS_Y:        r_pos_y      <= i_cfg_data[POS_Y_W-1:0];
                CFG_COMBINE_MODE: begin
                    if (i_cfg_data[OP_W-1:0] != OP_RESERVED) begin
                        r_combine_mode <= i_cfg_data[OP_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_row.valid || take_row;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // row counter and line offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_index <= '0;
            r_row_off   <= '0;
        end else if (accept) begin
            if (s_axis_tlast || (r_row_index == {ROW_W{1'b1}})) begin
                r_row_index <= '0;
                r_row_off   <= '0;
            end else begin
                r_row_index <= r_row_index + ROW_W'(1);
                r_row_off   <= r_row_off + ADDR_W'(LONGS_PER_LINE);
            end
        end
    end

    always_comb begin
        x_ext          = XCMP_W'(r_pos_x);
        x_group        = ADDR_W'(r_pos_x >>> 3);
        y_off          = ADDR_W'(ADDR_W'(r_pos_y) * ADDR_W'(LONGS_PER_LINE));
        n_row.valid    = 1'b1;
        n_row.left_en  = !r_pos_x[POS_X_W-1];
        n_row.right_en = (x_ext <= $signed(XCMP_W'(RIGHT_LIMIT)));
        n_line_off     = y_off + x_group;
        n_base_off     = r_frame_base + r_row_off +
                         (n_row.left_en ? ADDR_W'(0) : ADDR_W'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (accept) begin
            r_row <= n_row;
        end else if (take_row) begin
            r_row.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_off <= n_line_off;
            r_base_off <= n_base_off;
        end
    end

    psrb_lane u_lane_lo (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_long  (s_axis_tdata[LONG_W-1:0]),
        .i_shift (r_pos_x[SHIFT_W-1:0]),
        .o_left  (left_lo),
        .o_right (right_lo)
    );

    psrb_lane u_lane_hi (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_long  (s_axis_tdata[2*LONG_W-1:LONG_W]),
        .i_shift (r_pos_x[SHIFT_W-1:0]),
        .o_left  (left_hi),
        .o_right (right_hi)
    );

    psrb_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_row      (r_row),
        .i_left_lo  (left_lo),
        .i_left_hi  (left_hi),
        .i_right_lo (right_lo),
        .i_right_hi (right_hi),
        .i_line_off (r_line_off),
        .i_base_off (r_base_off),
        .o_take_row (take_row),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_addr     (out_addr),
        .o_data     (out_data),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, r_combine_mode, out_data, out_addr};

endmodule

>>> tb/tb_planar_sprite_row_blitter.sv
// Self-checking testbench for planar_sprite_row_blitter: streams sprite rows in random bursts,
// predicts the long write commands of each row and checks them against the master stream.
// Depends on psrb_pkg and the planar_sprite_row_blitter RTL.
`timescale 1ns / 100ps

module tb_planar_sprite_row_blitter;
    import psrb_pkg::*;

    localparam int LONGS_PER_LINE = DEF_LONGS_PER_LINE;
    localparam int RIGHT_LIMIT    = DEF_RIGHT_LIMIT;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [LONG_W-1:0] planes_low;
        logic [LONG_W-1:0] planes_high;
        logic              last_row;
    } t_row;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LONG_W-1:0] data;
        t_op               op;
        logic              last;
    } t_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // planes_low [31:0], planes_high [63:32]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // write_address [19:0], write_data [51:20], write_op [53:52], zero [55:54]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    t_row   row_queue[$];
    t_write pending_writes[$];
    t_row   current_row;
    t_write got_write;
    t_write exp_write;

    logic [ADDR_W-1:0]         cfg_frame_base;
    logic signed [POS_X_W-1:0] cfg_pos_x;
    logic [POS_Y_W-1:0]        cfg_pos_y;
    t_op                       cfg_mode;
    logic [ROW_W-1:0]          row_index_model;

    int  gap_left = 0;
    int  burst_left = 0;
    int  rx_mode = 0;
    int  rx_count = 0;
    int  rx_stall_left = 0;
    logic rx_ready_next;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    planar_sprite_row_blitter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Shadow of the configuration registers, sampled on the same edge as the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_frame_base <= '0;
            cfg_pos_x      <= '0;
            cfg_pos_y      <= '0;
            cfg_mode       <= OP_OR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_BASE: cfg_frame_base <= i_cfg_data[ADDR_W-1:0];
                CFG_POS_X:      cfg_pos_x <= i_cfg_data[POS_X_W-1:0];
                CFG_POS_Y:      cfg_pos_y <= i_cfg_data[POS_Y_W-1:0];
                CFG_COMBINE_MODE: begin
                    if (i_cfg_data[OP_W-1:0] != OP_RESERVED)
                        cfg_mode <= t_op'(i_cfg_data[OP_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    task automatic predict_row_writes(input t_row row);
        int x;
        int s;
        int start;
        logic [LONG_W-1:0] mask;
        logic [ADDR_W-1:0] base;
        begin
            x     = int'(cfg_pos_x);
            s     = x & 15;
            mask  = {2{WORD_W'((1 << s) - 1)}};
            start = (int'(cfg_pos_y) * LONGS_PER_LINE + (x >>> 3)) & ~1;
            base  = ADDR_W'(int'(cfg_frame_base) + start
                            + int'(row_index_model) * LONGS_PER_LINE);
            if (x >= 0) begin
                pending_writes.push_back('{base, (row.planes_low & ~mask) >> s,
                                           cfg_mode, 1'b0});
                pending_writes.push_back('{ADDR_W'(base + 1), (row.planes_high & ~mask) >> s,
                                           cfg_mode, x > RIGHT_LIMIT});
            end
            if (x <= RIGHT_LIMIT) begin
                pending_writes.push_back('{ADDR_W'(base + 2), (row.planes_low & mask) << (16 - s),
                                           cfg_mode, 1'b0});
                pending_writes.push_back('{ADDR_W'(base + 3),
                                           (row.planes_high & mask) << (16 - s),
                                           cfg_mode, 1'b1});
            end
            row_index_model = row.last_row ? '0 : row_index_model + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid   <= 1'b0;
            gap_left        = 0;
            burst_left      = 0;
            row_index_model = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_row_writes(current_row);
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (row_queue.size() > 0) begin
                current_row   = row_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {current_row.planes_high, current_row.planes_low};
                s_axis_tlast  <= current_row.last_row;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_write = '{m_axis_tdata[19:0], m_axis_tdata[51:20],
                              t_op'(m_axis_tdata[53:52]), m_axis_tlast};
                if (pending_writes.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected write: addr=%h data=%h op=%0d last=%b",
                                 got_write.addr, got_write.data, got_write.op, got_write.last);
                    mismatch_count++;
                end else begin
                    exp_write = pending_writes.pop_front();
                    if (got_write.addr !== exp_write.addr || got_write.data !== exp_write.data
                        || got_write.op !== exp_write.op || got_write.last !== exp_write.last) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("mismatch: expected addr=%h data=%h op=%0d last=%b",
                                     exp_write.addr, exp_write.data, exp_write.op,
                                     exp_write.last);
                            $display("          got      addr=%h data=%h op=%0d last=%b",
                                     got_write.addr, got_write.data, got_write.op,
                                     got_write.last);
                        end
                        mismatch_count++;
                    end
                end
            end
            rx_count++;
            case (rx_mode)
                0: rx_ready_next = 1'b1;
                1: rx_ready_next = ($urandom_range(0, 3) != 0);
                2: rx_ready_next = ((rx_count % 7) < 4);
                default: begin
                    if (rx_stall_left > 0) begin
                        rx_stall_left--;
                        rx_ready_next = 1'b0;
                    end else begin
                        rx_ready_next = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_stall_left = $urandom_range(1, 10);
                    end
                end
            endcase
            m_axis_tready <= rx_ready_next;
        end
    end

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_position(input int fb, input int x, input int y, input t_op mode);
        write_cfg(CFG_FRAME_BASE, CFG_DATA_W'(fb));
        write_cfg(CFG_POS_X, CFG_DATA_W'(x & 'h3FF));
        write_cfg(CFG_POS_Y, CFG_DATA_W'(y));
        write_cfg(CFG_COMBINE_MODE, CFG_DATA_W'(mode));
        rx_mode = $urandom_range(0, 3);
    endtask

    task automatic push_row(input logic [LONG_W-1:0] lo, input logic [LONG_W-1:0] hi,
                            input logic last);
        row_queue.push_back('{lo, hi, last});
    endtask

    // Wait until every item is taken and every write has come, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        while (row_queue.size() != 0 || s_axis_tvalid || pending_writes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [LONG_W-1:0] random_long();
        case ($urandom_range(0, 7))
            0: random_long = '1;
            1: random_long = '0;
            default: random_long = $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int px;
        int r;
        int x_cases[6];

        x_cases = '{7, 8, -8, 15, 1, 16};

        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, aligned sprite
        push_row('1, '1, 1'b0);
        push_row('0, '0, 1'b1);
        drain();

        set_position('hFFFFF, -15, 199, OP_XOR);
        push_row(32'hAAAA5555, 32'h5555AAAA, 1'b0);
        push_row('1, '0, 1'b1);
        drain();

        set_position(0, 319, 0, OP_OVERWRITE);
        push_row('1, '1, 1'b1);
        drain();

        // reserved combine mode leaves overwrite in force
        write_cfg(CFG_COMBINE_MODE, CFG_DATA_W'(OP_RESERVED));
        write_cfg(CFG_POS_X, CFG_DATA_W'(RIGHT_LIMIT));
        push_row(32'h12345678, 32'h9ABCDEF0, 1'b0);
        push_row(32'hFFFF0000, 32'h0000FFFF, 1'b1);
        drain();

        write_cfg(CFG_POS_X, CFG_DATA_W'(RIGHT_LIMIT + 1));
        push_row('1, 32'h0F0F0F0F, 1'b1);
        drain();

        set_position(0, -1, 0, OP_OR);
        push_row('1, '1, 1'b0);
        push_row(32'h80018001, 32'h7FFE7FFE, 1'b1);
        drain();

        foreach (x_cases[i]) begin
            px = x_cases[i];
            write_cfg(CFG_POS_X, CFG_DATA_W'(px & 'h3FF));
            push_row($urandom, $urandom, i[0]);
            drain();
        end

        // long sprite so the row counter wraps, moved to a random place per segment
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 4))
                0: px = -15 + $urandom_range(0, 14);
                1: px = RIGHT_LIMIT + 1 + $urandom_range(0, 14);
                2: px = $urandom_range(0, 15);
                3: px = RIGHT_LIMIT - $urandom_range(0, 8);
                default: px = $urandom_range(0, 334) - 15;
            endcase
            set_position(($urandom_range(0, 3) == 0) ? 'hFFFFF : $urandom_range(0, 'hFFFFF), px,
                         ($urandom_range(0, 3) == 0) ? 199 : $urandom_range(0, 199),
                         t_op'($urandom_range(0, 3)));
            for (r = 0; r < 32; r++)
                push_row(random_long(), random_long(), 1'b0);
            drain();
        end
        push_row($urandom, $urandom, 1'b1);
        drain();

        if (pending_writes.size() != 0)
            mismatch_count += pending_writes.size();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
